@@ rtl/lkv_pkg.sv @@
`timescale 1ns / 1ps

package lkv_pkg;

    // Default sizes of the store.
    localparam int ENTRIES_DEFAULT    = 8;
    localparam int KEY_BITS_DEFAULT   = 32;
    localparam int VALUE_BITS_DEFAULT = 32;

    // Capacity register.
    localparam int              CAP_W     = 4;
    localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

    // Operation codes.
    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic lookup;
        logic commit;
    } ctrl_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic out_blocked;
    } dp_status_t;

endpackage

@@ rtl/lkv_ram.sv @@
`timescale 1ns / 1ps

module lkv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/lkv_ctrl.sv @@
`timescale 1ns / 1ps

module lkv_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  lkv_pkg::dp_status_t   status,
    output lkv_pkg::ctrl_cmd_t    cmd
);

    lkv_pkg::state_t state_reg;
    lkv_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lkv_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lkv_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = lkv_pkg::ST_LOOKUP;
                end
            end
            lkv_pkg::ST_LOOKUP: begin
                state_next = lkv_pkg::ST_UPDATE;
            end
            lkv_pkg::ST_UPDATE: begin
                if (!status.out_blocked) begin
                    state_next = s_valid ? lkv_pkg::ST_LOOKUP : lkv_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lkv_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready    = 1'b0;
        cmd.load   = 1'b0;
        cmd.lookup = 1'b0;
        cmd.commit = 1'b0;
        case (state_reg)
            lkv_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            lkv_pkg::ST_LOOKUP: begin
                cmd.lookup = 1'b1;
            end
            lkv_pkg::ST_UPDATE: begin
                // The next transaction enters in the same cycle the current one retires.
                cmd.commit = !status.out_blocked;
                s_ready    = !status.out_blocked;
                cmd.load   = !status.out_blocked && s_valid;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

@@ rtl/lkv_datapath.sv @@
`timescale 1ns / 1ps

module lkv_datapath #(
    parameter int ENTRIES    = lkv_pkg::ENTRIES_DEFAULT,
    parameter int KEY_BITS   = lkv_pkg::KEY_BITS_DEFAULT,
    parameter int VALUE_BITS = lkv_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  lkv_pkg::ctrl_cmd_t           cmd,
    output lkv_pkg::dp_status_t          status,
    input  logic                         cfg_wr_en,
    input  logic [lkv_pkg::CAP_W-1:0]    cfg_wr_data,
    input  logic                         s_cmd,
    input  logic [KEY_BITS-1:0]          s_key,
    input  logic [VALUE_BITS-1:0]        s_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_found,
    output logic [VALUE_BITS-1:0]        m_read_value,
    output logic                         m_evicted,
    output logic [KEY_BITS-1:0]          m_evicted_key
);

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int CAP_W  = lkv_pkg::CAP_W;
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    // Registered transaction.
    logic                  cmd_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;

    // Entry state.
    logic [ENTRIES-1:0]    valid_reg, valid_next;
    logic [KEY_BITS-1:0]   key_arr_reg  [ENTRIES];
    logic [KEY_BITS-1:0]   key_arr_next [ENTRIES];
    logic [IDX_W-1:0]      rank_reg     [ENTRIES];
    logic [IDX_W-1:0]      rank_next    [ENTRIES];
    logic [CNT_W-1:0]      used_reg, used_next;
    logic [CAP_W-1:0]      cap_reg;

    // Lookup results.
    logic                  hit_reg;
    logic [ENTRIES-1:0]    hit_vec_reg;
    logic [IDX_W-1:0]      hit_idx_reg;
    logic [IDX_W-1:0]      hit_rank_reg;
    logic                  ev_reg;
    logic [ENTRIES-1:0]    victim_vec_reg;
    logic [ENTRIES-1:0]    slot_vec_reg;
    logic [IDX_W-1:0]      slot_idx_reg;

    // Output register.
    logic                  m_valid_reg;
    logic                  m_found_reg;
    logic [VALUE_BITS-1:0] m_read_value_reg;
    logic                  m_evicted_reg;
    logic [KEY_BITS-1:0]   m_evicted_key_reg;

    // Lookup logic.
    logic [ENTRIES-1:0]    match;
    logic [ENTRIES-1:0]    victim_vec;
    logic [ENTRIES-1:0]    free_vec;
    logic [ENTRIES-1:0]    slot_vec;
    logic [IDX_W-1:0]      hit_idx;
    logic [IDX_W-1:0]      hit_rank;
    logic [IDX_W-1:0]      victim_idx;
    logic [IDX_W-1:0]      slot_idx;
    logic [CNT_W-1:0]      used_m1;
    logic [IDX_W-1:0]      last_rank;
    logic [CMP_W-1:0]      cap_ext;
    logic [CMP_W-1:0]      eff_cap;
    logic                  need_evict;

    // Memory ports.
    logic                  dram_we;
    logic [IDX_W-1:0]      dram_waddr;
    logic [VALUE_BITS-1:0] dram_rdata;
    logic                  kram_we;
    logic [KEY_BITS-1:0]   kram_rdata;

    always_comb begin
        cap_ext = CMP_W'(cap_reg);
        if (cap_ext == '0) begin
            eff_cap = CMP_W'(1);
        end else if (cap_ext > CMP_W'(ENTRIES)) begin
            eff_cap = CMP_W'(ENTRIES);
        end else begin
            eff_cap = cap_ext;
        end
        need_evict = (CMP_W'(used_reg) >= eff_cap) && (used_reg != '0);
        used_m1    = used_reg - CNT_W'(1);
        last_rank  = used_m1[IDX_W-1:0];
    end

    always_comb begin
        hit_idx    = '0;
        victim_idx = '0;
        slot_idx   = '0;
        hit_rank   = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            match[i]      = valid_reg[i] && (key_arr_reg[i] == key_reg);
            victim_vec[i] = valid_reg[i] && (rank_reg[i] == last_rank);
        end
        free_vec = ~valid_reg | (need_evict ? victim_vec : '0);
        slot_vec = free_vec & (~free_vec + ENTRIES'(1));
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_idx = IDX_W'(i);
            end
            if (victim_vec[i]) begin
                victim_idx = IDX_W'(i);
            end
            if (free_vec[i]) begin
                slot_idx = IDX_W'(i);
            end
        end
        // Keys are unique, so at most one entry matches.
        for (int i = 0; i < ENTRIES; i++) begin
            hit_rank = hit_rank | (match[i] ? rank_reg[i] : '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg   <= s_cmd;
            key_reg   <= s_key;
            value_reg <= s_value;
        end
        if (cmd.lookup) begin
            hit_reg        <= |match;
            hit_vec_reg    <= match;
            hit_idx_reg    <= hit_idx;
            hit_rank_reg   <= hit_rank;
            ev_reg         <= need_evict;
            victim_vec_reg <= victim_vec;
            slot_vec_reg   <= slot_vec;
            slot_idx_reg   <= slot_idx;
        end
    end

    // Entry update on commit.
    always_comb begin
        valid_next   = valid_reg;
        key_arr_next = key_arr_reg;
        rank_next    = rank_reg;
        used_next    = used_reg;
        dram_we      = 1'b0;
        dram_waddr   = hit_idx_reg;
        kram_we      = 1'b0;
        if (cmd.commit) begin
            if (hit_reg) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (hit_vec_reg[i]) begin
                        rank_next[i] = '0;
                    end else if (valid_reg[i] && (rank_reg[i] < hit_rank_reg)) begin
                        rank_next[i] = rank_reg[i] + IDX_W'(1);
                    end
                end
                dram_we = (cmd_reg == lkv_pkg::CMD_PUT);
            end else if (cmd_reg == lkv_pkg::CMD_PUT) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    valid_next[i] = valid_reg[i] && !(ev_reg && victim_vec_reg[i]);
                    if (valid_next[i]) begin
                        rank_next[i] = rank_reg[i] + IDX_W'(1);
                    end
                    if (slot_vec_reg[i]) begin
                        valid_next[i]   = 1'b1;
                        key_arr_next[i] = key_reg;
                        rank_next[i]    = '0;
                    end
                end
                used_next  = used_reg - (ev_reg ? CNT_W'(1) : CNT_W'(0)) + CNT_W'(1);
                dram_we    = 1'b1;
                dram_waddr = slot_idx_reg;
                kram_we    = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            used_reg  <= '0;
            cap_reg   <= lkv_pkg::CAP_RESET;
        end else begin
            valid_reg <= valid_next;
            used_reg  <= used_next;
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        key_arr_reg <= key_arr_next;
        rank_reg    <= rank_next;
    end

    lkv_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (ENTRIES)
    ) u_data_ram (
        .aclk    (aclk),
        .wr_en   (dram_we),
        .wr_addr (dram_waddr),
        .wr_data (value_reg),
        .rd_en   (cmd.lookup),
        .rd_addr (hit_idx),
        .rd_data (dram_rdata)
    );

    // Copy of the keys, read at the victim for the eviction report.
    lkv_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (ENTRIES)
    ) u_key_ram (
        .aclk    (aclk),
        .wr_en   (kram_we),
        .wr_addr (slot_idx_reg),
        .wr_data (key_reg),
        .rd_en   (cmd.lookup),
        .rd_addr (victim_idx),
        .rd_data (kram_rdata)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_found_reg       <= hit_reg;
            m_read_value_reg  <= (hit_reg && (cmd_reg == lkv_pkg::CMD_GET)) ? dram_rdata : '0;
            m_evicted_reg     <= !hit_reg && (cmd_reg == lkv_pkg::CMD_PUT) && ev_reg;
            m_evicted_key_reg <= (!hit_reg && (cmd_reg == lkv_pkg::CMD_PUT) && ev_reg) ?
                                 kram_rdata : '0;
        end
    end

    assign status.out_blocked = m_valid_reg && !m_ready;
    assign m_valid       = m_valid_reg;
    assign m_found       = m_found_reg;
    assign m_read_value  = m_read_value_reg;
    assign m_evicted     = m_evicted_reg;
    assign m_evicted_key = m_evicted_key_reg;

`ifndef NO_ASSERTIONS
    a_count_matches_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_reg) == int'(used_reg))
        else $error("used count disagrees with valid entries");

    a_unique_match: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.lookup |-> $onehot0(match))
        else $error("key present in more than one entry");

    a_hit_most_recent: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && hit_reg) |=> (rank_reg[$past(hit_idx_reg)] == '0))
        else $error("hit entry not made most recent");

    a_used_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && !hit_reg && (cmd_reg == lkv_pkg::CMD_PUT)) |=>
        (used_reg != '0) && (int'(used_reg) <= ENTRIES))
        else $error("used count out of range after insert");
`endif

endmodule

@@ rtl/lru_key_value_cache_core.sv @@
`timescale 1ns / 1ps

// Channel   Ports                                            Direction
// input     s_valid s_ready s_cmd s_key s_value              get/put request in
// result    m_valid m_ready m_found m_read_value             one result out per request
//           m_evicted m_evicted_key
// config    cfg_wr_en cfg_wr_data                            capacity write, no read-back
//
// Each transaction has a lookup step, which compares the key against all entries in
// parallel and reads the value and victim key memories, then an update step for ranks
// and entries. A new request is taken in the update cycle, as the current one retires,
// so back-to-back requests never overlap their use of the shared entry state.
// Reset (aresetn, synchronous, active low) empties the store and sets capacity to 8.
// A stalled result holds the update cycle until the result register drains.

module lru_key_value_cache_core #(
    parameter int ENTRIES    = lkv_pkg::ENTRIES_DEFAULT,
    parameter int KEY_BITS   = lkv_pkg::KEY_BITS_DEFAULT,
    parameter int VALUE_BITS = lkv_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [lkv_pkg::CAP_W-1:0]  cfg_wr_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_cmd,
    input  logic [KEY_BITS-1:0]        s_key,
    input  logic [VALUE_BITS-1:0]      s_value,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_found,
    output logic [VALUE_BITS-1:0]      m_read_value,
    output logic                       m_evicted,
    output logic [KEY_BITS-1:0]        m_evicted_key
);

    // Commands from the sequencer and the result-register status back to it.
    lkv_pkg::ctrl_cmd_t  cmd;
    lkv_pkg::dp_status_t status;

    // The sequencer walks each transaction through lookup and update.
    lkv_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // The datapath holds the entries, recency ranks, capacity and result register.
    lkv_datapath #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_cmd         (s_cmd),
        .s_key         (s_key),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_found       (m_found),
        .m_read_value  (m_read_value),
        .m_evicted     (m_evicted),
        .m_evicted_key (m_evicted_key)
    );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the LRU key-value cache core.
// A directed table is walked first, then eight random phases run, each
// with its own capacity setting. Every accepted request goes through a
// behavioral LRU predictor, and each result transaction is checked
// against the oldest expected result still waiting.
module tb_top;

    localparam int N_SLOTS     = lkv_pkg::ENTRIES_DEFAULT;
    localparam int CAP_BITS    = lkv_pkg::CAP_W;
    localparam int CYCLE_LIMIT = 100000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 205;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 10;

    // A directed row either carries its result inline or defers to the predictor.
    localparam logic BY_MODEL = 1'b0;
    localparam logic TYPED    = 1'b1;

    typedef struct packed {
        logic        found;
        logic [31:0] read_value;
        logic        evicted;
        logic [31:0] evicted_key;
    } lookup_result_t;

    typedef struct packed {
        logic           cmd;
        logic [31:0]    key;
        logic [31:0]    value;
        logic           typed;
        lookup_result_t want;
    } stim_row_t;

    localparam lookup_result_t MISS = '0;

    // Directed table. It starts on an empty store at the reset capacity of 8.
    // It covers misses on an empty store, all-zero and all-one keys and values,
    // update of a present key, a full store evicting its least recent entry,
    // a lookup of the evicted key, and recency changes caused by hits.
    localparam int N_DIRECTED = 22;
    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        '{lkv_pkg::CMD_GET, 32'h0000_0000, 32'h0000_0000, TYPED, MISS},
        '{lkv_pkg::CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000, TYPED, MISS},
        '{lkv_pkg::CMD_PUT, 32'h0000_0000, 32'hFFFF_FFFF, TYPED, MISS},
        '{lkv_pkg::CMD_PUT, 32'hFFFF_FFFF, 32'h0000_0000, TYPED, MISS},
        '{lkv_pkg::CMD_GET, 32'h0000_0000, 32'h0000_0000, TYPED,
          '{1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0}},
        '{lkv_pkg::CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000, TYPED,
          '{1'b1, 32'h0, 1'b0, 32'h0}},
        '{lkv_pkg::CMD_PUT, 32'h0000_0000, 32'h5A5A_5A5A, TYPED,
          '{1'b1, 32'h0, 1'b0, 32'h0}},
        '{lkv_pkg::CMD_GET, 32'h0000_0000, 32'h0000_0000, TYPED,
          '{1'b1, 32'h5A5A_5A5A, 1'b0, 32'h0}},
        '{lkv_pkg::CMD_PUT, 32'h0000_0001, 32'h1111_1111, BY_MODEL, MISS},
        '{lkv_pkg::CMD_PUT, 32'h0000_0002, 32'h2222_2222, BY_MODEL, MISS},
        '{lkv_pkg::CMD_PUT, 32'h0000_0003, 32'h3333_3333, BY_MODEL, MISS},
        '{lkv_pkg::CMD_PUT, 32'h0000_0004, 32'h4444_4444, BY_MODEL, MISS},
        '{lkv_pkg::CMD_PUT, 32'h0000_0005, 32'h5555_5555, BY_MODEL, MISS},
        '{lkv_pkg::CMD_PUT, 32'h0000_0006, 32'h6666_6666, BY_MODEL, MISS},
        '{lkv_pkg::CMD_PUT, 32'h0000_0007, 32'h7777_7777, BY_MODEL, MISS},
        '{lkv_pkg::CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000, TYPED, MISS},
        '{lkv_pkg::CMD_GET, 32'h0000_0001, 32'h0000_0000, BY_MODEL, MISS},
        '{lkv_pkg::CMD_PUT, 32'h0000_0008, 32'h8888_8888, BY_MODEL, MISS},
        '{lkv_pkg::CMD_PUT, 32'h8000_0000, 32'hA5A5_A5A5, BY_MODEL, MISS},
        '{lkv_pkg::CMD_GET, 32'h8000_0000, 32'hFFFF_FFFF, BY_MODEL, MISS},
        '{lkv_pkg::CMD_PUT, 32'h0000_0007, 32'h0000_0000, BY_MODEL, MISS},
        '{lkv_pkg::CMD_GET, 32'h0000_0000, 32'h0000_0000, BY_MODEL, MISS}
    };

    // DUT ports. Every input is known from time zero.
    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [CAP_BITS-1:0]  cfg_wr_data = '0;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    logic                 s_cmd       = lkv_pkg::CMD_GET;
    logic [31:0]          s_key       = '0;
    logic [31:0]          s_value     = '0;
    logic                 m_valid;
    logic                 m_ready     = 1'b0;
    logic                 m_found;
    logic [31:0]          m_read_value;
    logic                 m_evicted;
    logic [31:0]          m_evicted_key;

    // These travel with the payload so that a directed row's inline result
    // is attached to the transaction that carries it.
    logic                 row_typed = BY_MODEL;
    lookup_result_t       row_want  = MISS;

    // Predictor state: a behavioral copy of the store.
    logic                 slot_used [N_SLOTS] = '{default: 1'b0};
    logic [31:0]          slot_key  [N_SLOTS] = '{default: '0};
    logic [31:0]          slot_val  [N_SLOTS] = '{default: '0};
    int                   slot_age  [N_SLOTS] = '{default: 0};
    int                   fill_count = 0;
    logic [CAP_BITS-1:0]  cap_reg    = lkv_pkg::CAP_RESET;

    lookup_result_t       pending_results [$];

    int                   cycle_count   = 0;
    int                   fail_count    = 0;
    int                   request_count = 0;
    int                   hit_count     = 0;
    int                   evict_count   = 0;
    bit                   no_idle       = 1'b0;
    bit                   hold_req      = 1'b0;

    lru_key_value_cache_core i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_key         (s_key),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_found       (m_found),
        .m_read_value  (m_read_value),
        .m_evicted     (m_evicted),
        .m_evicted_key (m_evicted_key)
    );

    always #5 aclk = ~aclk;

    // Capacity as the block uses it: zero acts as one, and anything above
    // the number of slots is clamped to the number of slots.
    function automatic int effective_cap(input logic [CAP_BITS-1:0] cap);
        if (cap == 0) begin
            return 1;
        end
        return (cap > N_SLOTS) ? N_SLOTS : int'(cap);
    endfunction

    // Computes the result of one request and advances the store copy.
    // Age 0 is the most recent entry, and live entries hold ages 0 .. fill_count-1.
    task automatic lru_predict(input logic cmd, input logic [31:0] key,
                               input logic [31:0] value, output lookup_result_t res);
        int hit_slot;
        int free_slot;
        int old_age;
        hit_slot  = -1;
        free_slot = -1;
        res       = MISS;
        for (int i = 0; i < N_SLOTS; i++) begin
            if (hit_slot < 0 && slot_used[i] && slot_key[i] == key) begin
                hit_slot = i;
            end
        end
        if (hit_slot >= 0) begin
            res.found = 1'b1;
            if (cmd == lkv_pkg::CMD_GET) begin
                res.read_value = slot_val[hit_slot];
            end else begin
                slot_val[hit_slot] = value;
            end
            // Only entries that were more recent than the hit grow older.
            old_age = slot_age[hit_slot];
            for (int i = 0; i < N_SLOTS; i++) begin
                if (slot_used[i] && slot_age[i] < old_age) begin
                    slot_age[i]++;
                end
            end
            slot_age[hit_slot] = 0;
        end else if (cmd == lkv_pkg::CMD_PUT) begin
            // A lowered capacity sheds one entry per new key, never more.
            if (fill_count >= effective_cap(cap_reg) && fill_count > 0) begin
                for (int i = 0; i < N_SLOTS; i++) begin
                    if (!res.evicted && slot_used[i] && slot_age[i] == fill_count - 1) begin
                        res.evicted     = 1'b1;
                        res.evicted_key = slot_key[i];
                        slot_used[i]    = 1'b0;
                        fill_count--;
                    end
                end
            end
            for (int i = 0; i < N_SLOTS; i++) begin
                if (free_slot < 0 && !slot_used[i]) begin
                    free_slot = i;
                end
            end
            if (free_slot >= 0) begin
                for (int i = 0; i < N_SLOTS; i++) begin
                    if (slot_used[i]) begin
                        slot_age[i]++;
                    end
                end
                slot_used[free_slot] = 1'b1;
                slot_key[free_slot]  = key;
                slot_val[free_slot]  = value;
                slot_age[free_slot]  = 0;
                fill_count++;
            end
        end
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        end
    endtask

    // Monitor. Both channels are sampled at the rising edge, before the bench's
    // own nonblocking updates land. The result side is handled first, so a
    // result can never be matched against a request accepted on the same edge.
    always @(posedge aclk) begin
        lookup_result_t predicted;
        lookup_result_t oldest;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    fail_count++;
                    $display("%0t: result transaction with no request outstanding", $time);
                end else begin
                    oldest = pending_results.pop_front();
                    check_field("found",       32'(oldest.found),   32'(m_found));
                    check_field("read_value",  oldest.read_value,   m_read_value);
                    check_field("evicted",     32'(oldest.evicted), 32'(m_evicted));
                    check_field("evicted_key", oldest.evicted_key,  m_evicted_key);
                end
            end
            if (s_valid && s_ready) begin
                lru_predict(s_cmd, s_key, s_value, predicted);
                request_count++;
                hit_count   += int'(predicted.found);
                evict_count += int'(predicted.evicted);
                pending_results.insert(pending_results.size(),
                                       (row_typed == TYPED) ? row_want : predicted);
            end
        end
    end

    // Result-side backpressure. It is normally random, it is held fully open
    // during the quiet phase, and once it blocks for a long stretch on request.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= no_idle || ($urandom_range(99) >= 10);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Presents one request and returns on the edge where it is accepted.
    // Valid is left high, so the caller decides whether the next request
    // follows directly or a gap comes first.
    task automatic offer_item(input logic cmd, input logic [31:0] key, input logic [31:0] value,
                              input logic typed, input lookup_result_t want);
        s_valid   <= 1'b1;
        s_cmd     <= cmd;
        s_key     <= key;
        s_value   <= value;
        row_typed <= typed;
        row_want  <= want;
        do begin
            @(posedge aclk);
        end while (!s_ready);
    endtask

    task automatic maybe_gap();
        if (!no_idle && $urandom_range(99) < 10) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    // Lowers valid and waits until every outstanding result has come back.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // A capacity write is only issued once the store is idle.
    task automatic write_capacity(input logic [CAP_BITS-1:0] cap);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(posedge aclk);
        cap_reg = cap;
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        logic [CAP_BITS-1:0] cap_plan [PHASES];
        logic [31:0]         key_pool [N_SLOTS + 3];
        logic [31:0]         key;
        int                  pool_size;
        int                  pick;

        // The first plan entry drops capacity far below what the directed part
        // leaves stored. Zero and fifteen exercise the clamping at both ends.
        cap_plan = '{4'd2, 4'd0, 4'd15, 4'd1, 4'd8, 4'd5,
                     CAP_BITS'($urandom_range(0, 15)), CAP_BITS'($urandom_range(0, 15))};

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < N_DIRECTED; r++) begin
            offer_item(DIRECTED[r].cmd, DIRECTED[r].key, DIRECTED[r].value,
                       DIRECTED[r].typed, DIRECTED[r].want);
            maybe_gap();
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            write_capacity(cap_plan[ph]);
            no_idle = (ph == 4);
            // In phase two the result side stalls while requests keep coming,
            // which backs the block up until it stops accepting input.
            if (ph == 2) begin
                hold_req = 1'b1;
            end

            // The key pool is a little larger than the capacity, so hits,
            // updates and evictions all happen often.
            pool_size = effective_cap(cap_plan[ph]) + 3;
            for (int i = 0; i < pool_size; i++) begin
                key_pool[i] = $urandom;
            end

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 1 && n == PHASE_ITEMS / 2) begin
                    drain();
                end
                pick = $urandom_range(99);
                if (pick < 80) begin
                    key = key_pool[$urandom_range(0, pool_size - 1)];
                end else if (pick < 90) begin
                    key = $urandom;
                end else begin
                    key = (pick < 95) ? 32'h0000_0000 : 32'hFFFF_FFFF;
                end
                offer_item(($urandom_range(99) < 45) ? lkv_pkg::CMD_PUT : lkv_pkg::CMD_GET,
                           key, $urandom, BY_MODEL, MISS);
                maybe_gap();
            end
        end

        drain();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (pending_results.size() != 0) begin
            fail_count++;
            $display("%0t: %0d results never arrived", $time, pending_results.size());
        end

        $display("Checked %0d request transactions (%0d hits, %0d evictions) in %0d cycles.",
                 request_count, hit_count, evict_count, cycle_count);
        $display("Capacity settings ran from 0 to 15, including a cut below the fill level.");
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
